[rtl/core/erpm_telemetry_decoder_macros.svh]
// assertion macros shared by the decoder rtl
`ifndef ERPM_TELEMETRY_DECODER_MACROS_SVH
`define ERPM_TELEMETRY_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ERPM_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("erpm telemetry decoder check failed");
// next-cycle implication
`define ERPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("erpm telemetry decoder check failed");
`else
`define ERPM_ASSERT(label, clk, rst, ante, cons)
`define ERPM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/erpm_td_pkg.sv]
`timescale 1ns / 1ps

package erpm_td_pkg;

   // field widths
   localparam int MOTOR_W  = 2;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 3;
   localparam int RPM_W    = 26;
   localparam int COND_W   = 12;
   localparam int MASK_W   = 4;

   localparam int MOTOR_COUNT = 4;

   // frame geometry
   localparam int FRAME_BITS = 21;
   localparam int BC_W       = 5;
   localparam logic [BC_W-1:0] BC_FULL = BC_W'(FRAME_BITS);
   localparam logic [BC_W-1:0] BC_OVER = BC_W'(FRAME_BITS + 1);
   // raw inverted countdown above which the duration exceeds a frame
   localparam logic [6:0] DUR_RAW_LIMIT = 7'(4 * FRAME_BITS);

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_STOPPED     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_CAPTURE  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FRAME   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_PERIOD = 3'd4;

   // configuration registers
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_DSHOT_ENABLE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLE_COUNT   = 4'd1;
   localparam logic [6:0] RESET_POLE_COUNT = 7'd14;

   // rpm arithmetic
   localparam int DIVIDEND_W = 26;
   localparam int DIVISOR_W  = 16;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
   localparam logic [DIVIDEND_W-1:0] RPM_NUMERATOR = 26'd60000000;
   localparam logic [DIVIDEND_W-1:0] RPM_OFFSET    = 26'd50;
   localparam logic [COND_W-1:0]     COND_STOPPED  = 12'hFFF;
   localparam logic [3:0]            CSUM_GOOD     = 4'hF;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   // gcr code to {valid, nibble}
   function automatic logic [4:0] gcr_decode(input logic [4:0] code);
      logic [4:0] entry;
      unique case (code)
         5'd9:    entry = 5'h19;
         5'd10:   entry = 5'h1A;
         5'd11:   entry = 5'h1B;
         5'd13:   entry = 5'h1D;
         5'd14:   entry = 5'h1E;
         5'd15:   entry = 5'h1F;
         5'd18:   entry = 5'h12;
         5'd19:   entry = 5'h13;
         5'd21:   entry = 5'h15;
         5'd22:   entry = 5'h16;
         5'd23:   entry = 5'h17;
         5'd25:   entry = 5'h10;
         5'd26:   entry = 5'h18;
         5'd27:   entry = 5'h11;
         5'd29:   entry = 5'h14;
         5'd30:   entry = 5'h1C;
         default: entry = 5'h00;
      endcase
      return entry;
   endfunction

endpackage

[rtl/core/erpm_td_if.sv]
`timescale 1ns / 1ps

interface erpm_td_req_if import erpm_td_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MOTOR_W-1:0] motor;
   logic [WORD_W-1:0]  capture_word;
   logic               first_word;
   logic               last_word;

   modport source (output valid, motor, capture_word, first_word, last_word, input ready);
   modport sink   (input valid, motor, capture_word, first_word, last_word, output ready);
endinterface

interface erpm_td_rsp_if import erpm_td_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MOTOR_W-1:0]  motor_id;
   logic [STATUS_W-1:0] status;
   logic [RPM_W-1:0]    rpm;
   logic                rpm_written;
   logic [COND_W-1:0]   condensed_value;
   logic [MASK_W-1:0]   fail_mask;

   modport source (output valid, motor_id, status, rpm, rpm_written, condensed_value,
                   fail_mask, input ready);
   modport sink   (input valid, motor_id, status, rpm, rpm_written, condensed_value,
                   fail_mask, output ready);
endinterface

interface erpm_td_csr_if import erpm_td_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/erpm_td_divider.sv]
`timescale 1ns / 1ps

// bit-serial restoring divider, one quotient bit per cycle
module erpm_td_divider import erpm_td_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DIV_CNT_W'(DIVIDEND_W - 1);
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/core/erpm_telemetry_decoder.sv]
`timescale 1ns / 1ps
// bidirectional dshot erpm telemetry decoder, one shared decoder for all motors
// req_bus: one transaction per captured edge word (motor, capture_word, first and
//   last word flags); first_word starts a frame, last_word triggers decode
// rsp_bus: one transaction per frame, on last_word only: motor_id, status, rpm,
//   rpm_written, condensed_value and the per-motor fail_mask after the frame
// csr_bus: register 0 dshot_enable, register 1 pole_count; always ready
// a data word shifts its duration (0..21 bits) in, one bit per cycle, in the bit shifter
// a last word then adds the decode: its own bit shifting, ones padding to the full
//   frame, four gcr digits, a check, two serial divisions of 26 quotient bits
//   and the output register; failed and stopped frames skip the divides
// req_bus.ready is high only while no word is in progress
// the result sits in an output register; a stalled receiver holds it while the
//   next frame's words are taken, and only a second finished result waits
// reset (synchronous, active high) clears frame state, fail bits and rsp valid;
//   registers return to enabled with 14 poles
`include "erpm_telemetry_decoder_macros.svh"

module erpm_telemetry_decoder import erpm_td_pkg::*; #(
   parameter int WORDS_PER_FRAME = 32
) (
   input logic clock,
   input logic reset,
   erpm_td_req_if.sink   req_bus,
   erpm_td_rsp_if.source rsp_bus,
   erpm_td_csr_if.sink   csr_bus
);

   localparam int WIDX_W = $clog2(WORDS_PER_FRAME);
   localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(WORDS_PER_FRAME - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHIFT = 3'd1;
   localparam logic [2:0] ST_PAD   = 3'd2;
   localparam logic [2:0] ST_GCR   = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_DIV1  = 3'd5;
   localparam logic [2:0] ST_DIV2  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0]            state_ff, state_in;
   // frame state
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [BC_W-1:0]       bit_count_ff, bit_count_in;
   logic                  ended_ff, ended_in;
   logic                  capture_ff, capture_in;
   logic [WIDX_W-1:0]     widx_ff, widx_in;
   logic                  last_ff, last_in;
   logic [MOTOR_W-1:0]    motor_ff, motor_in;
   logic                  level_ff, level_in;
   logic [BC_W-1:0]       dur_ff, dur_in;
   // gcr decode
   logic [1:0]            digit_ff, digit_in;
   logic [15:0]           nib_ff, nib_in;
   logic [3:0]            csum_ff, csum_in;
   logic                  bad_ff, bad_in;
   // staged result
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [RPM_W-1:0]      res_rpm_ff, res_rpm_in;
   logic                  res_written_ff, res_written_in;
   logic [COND_W-1:0]     res_cond_ff, res_cond_in;
   logic [MASK_W-1:0]     fail_ff, fail_in;
   // registers
   logic                  enable_ff, enable_in;
   logic [6:0]            pole_ff, pole_in;
   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MOTOR_W-1:0]    rsp_motor_ff, rsp_motor_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [RPM_W-1:0]      rsp_rpm_ff, rsp_rpm_in;
   logic                  rsp_written_ff, rsp_written_in;
   logic [COND_W-1:0]     rsp_cond_ff, rsp_cond_in;
   logic [MASK_W-1:0]     rsp_fail_ff, rsp_fail_in;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  req_accept;
   logic                  motor_ok;
   logic [6:0]            raw_low;
   logic                  too_long;
   logic [7:0]            raw_sum;
   logic [BC_W-1:0]       word_dur;
   logic [4:0]            gcr_code;
   logic [4:0]            gcr_entry;
   logic [COND_W-1:0]     cond;
   logic [5:0]            half_poles;
   logic [MASK_W-1:0]     motor_bit;
   logic                  out_load;

   erpm_td_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign motor_ok      = int'(req_bus.motor) < MOTOR_COUNT;

   // duration = (inverted countdown + 3) / 4, only the low bits matter below the limit
   assign raw_low  = ~req_bus.capture_word[6:0];
   assign too_long = (|(~req_bus.capture_word[30:7])) || (raw_low > DUR_RAW_LIMIT);
   assign raw_sum  = {1'b0, raw_low} + 8'd3;
   assign word_dur = raw_sum[6:2];

   // transition decode of the low digit, one 5-bit code a cycle
   assign gcr_code  = shift_ff[4:0] ^ shift_ff[5:1];
   assign gcr_entry = gcr_decode(gcr_code);

   assign cond       = nib_ff[15:4];
   assign half_poles = (pole_ff[6:1] == '0) ? 6'd1 : pole_ff[6:1];
   assign motor_bit  = MASK_W'(1) << motor_ff;
   assign out_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   assign csr_bus.ready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      shift_in       = shift_ff;
      bit_count_in   = bit_count_ff;
      ended_in       = ended_ff;
      capture_in     = capture_ff;
      widx_in        = widx_ff;
      last_in        = last_ff;
      motor_in       = motor_ff;
      level_in       = level_ff;
      dur_in         = dur_ff;
      digit_in       = digit_ff;
      nib_in         = nib_ff;
      csum_in        = csum_ff;
      bad_in         = bad_ff;
      res_status_in  = res_status_ff;
      res_rpm_in     = res_rpm_ff;
      res_written_in = res_written_ff;
      res_cond_in    = res_cond_ff;
      fail_in        = fail_ff;
      enable_in      = enable_ff;
      pole_in        = pole_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_motor_in   = rsp_motor_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_rpm_in     = rsp_rpm_ff;
      rsp_written_in = rsp_written_ff;
      rsp_cond_in    = rsp_cond_ff;
      rsp_fail_in    = rsp_fail_ff;
      div_req.start    = 1'b0;
      div_req.dividend = RPM_NUMERATOR;
      div_req.divisor  = DIVISOR_W'({7'd0, cond[8:0]}) << cond[11:9];

      // register writes
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_DSHOT_ENABLE: enable_in = csr_bus.data[0];
            CSR_POLE_COUNT:   pole_in   = csr_bus.data[6:0];
            default:          ;
         endcase
      end

      // result leaves when taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && enable_ff && motor_ok) begin
               motor_in = req_bus.motor;
               last_in  = req_bus.last_word;
               if (req_bus.first_word) begin
                  // start of frame, word 0 only flags the capture
                  shift_in     = '0;
                  bit_count_in = '0;
                  ended_in     = 1'b0;
                  capture_in   = |req_bus.capture_word;
                  widx_in      = '0;
                  if (req_bus.last_word) begin
                     state_in = ST_PAD;
                  end
               end else begin
                  if (widx_ff != WIDX_LAST) begin
                     widx_in = widx_ff + 1'b1;
                     if (!ended_ff) begin
                        if (too_long) begin
                           ended_in = 1'b1;
                        end else if (word_dur != '0) begin
                           dur_in   = word_dur;
                           level_in = ~req_bus.capture_word[WORD_W-1];
                           state_in = ST_SHIFT;
                        end
                     end
                  end
                  if (req_bus.last_word && state_in != ST_SHIFT) begin
                     state_in = ST_PAD;
                  end
               end
            end
         end

         ST_SHIFT: begin
            // one level bit a cycle, count saturates one past a frame
            shift_in = {shift_ff[FRAME_BITS-2:0], level_ff};
            if (bit_count_ff != BC_OVER) begin
               bit_count_in = bit_count_ff + 1'b1;
            end
            dur_in = dur_ff - 1'b1;
            if (dur_ff == BC_W'(1)) begin
               state_in = last_ff ? ST_PAD : ST_IDLE;
            end
         end

         ST_PAD: begin
            res_rpm_in     = '0;
            res_written_in = 1'b0;
            res_cond_in    = '0;
            if (!capture_ff) begin
               res_status_in = STATUS_NO_CAPTURE;
               state_in      = ST_OUT;
            end else if (bit_count_ff == BC_OVER) begin
               res_status_in = STATUS_BAD_FRAME;
               state_in      = ST_OUT;
            end else if (bit_count_ff != BC_FULL) begin
               // pad the frame with ones
               shift_in     = {shift_ff[FRAME_BITS-2:0], 1'b1};
               bit_count_in = bit_count_ff + 1'b1;
            end else begin
               digit_in = '0;
               csum_in  = '0;
               bad_in   = 1'b0;
               state_in = ST_GCR;
            end
         end

         ST_GCR: begin
            if (!gcr_entry[4]) begin
               bad_in = 1'b1;
            end
            nib_in   = {gcr_entry[3:0], nib_ff[15:4]};
            csum_in  = csum_ff ^ gcr_entry[3:0];
            shift_in = shift_ff >> 5;
            digit_in = digit_ff + 1'b1;
            if (digit_ff == 2'd3) begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            res_cond_in = cond;
            if (bad_ff || csum_ff != CSUM_GOOD) begin
               res_status_in = STATUS_BAD_FRAME;
               res_cond_in   = '0;
               state_in      = ST_OUT;
            end else if (cond == COND_STOPPED) begin
               res_status_in  = STATUS_STOPPED;
               res_written_in = 1'b1;
               state_in       = ST_OUT;
            end else if (cond[8:0] == '0) begin
               res_status_in = STATUS_ZERO_PERIOD;
               state_in      = ST_OUT;
            end else begin
               // 60e6 / period first, the +50 is exact after division
               div_req.start = 1'b1;
               state_in      = ST_DIV1;
            end
         end

         ST_DIV1: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quotient + RPM_OFFSET;
               div_req.divisor  = DIVISOR_W'(half_poles);
               state_in         = ST_DIV2;
            end
         end

         ST_DIV2: begin
            if (div_rsp.done) begin
               res_status_in  = STATUS_OK;
               res_rpm_in     = div_rsp.quotient;
               res_written_in = 1'b1;
               state_in       = ST_OUT;
            end
         end

         ST_OUT: begin
            if (out_load) begin
               // fail bit: cleared on a good rpm, kept when stopped, set otherwise
               if (res_status_ff == STATUS_OK) begin
                  fail_in = fail_ff & ~motor_bit;
               end else if (res_status_ff != STATUS_STOPPED) begin
                  fail_in = fail_ff | motor_bit;
               end
               rsp_valid_in   = 1'b1;
               rsp_motor_in   = motor_ff;
               rsp_status_in  = res_status_ff;
               rsp_rpm_in     = res_rpm_ff;
               rsp_written_in = res_written_ff;
               rsp_cond_in    = res_cond_ff;
               rsp_fail_in    = fail_in;
               // frame done, back to no capture
               shift_in     = '0;
               bit_count_in = '0;
               ended_in     = 1'b0;
               capture_in   = 1'b0;
               widx_in      = '0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shift_ff     <= '0;
         bit_count_ff <= '0;
         ended_ff     <= 1'b0;
         capture_ff   <= 1'b0;
         widx_ff      <= '0;
         fail_ff      <= '0;
         enable_ff    <= 1'b1;
         pole_ff      <= RESET_POLE_COUNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         bit_count_ff <= bit_count_in;
         ended_ff     <= ended_in;
         capture_ff   <= capture_in;
         widx_ff      <= widx_in;
         fail_ff      <= fail_in;
         enable_ff    <= enable_in;
         pole_ff      <= pole_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff        <= last_in;
      motor_ff       <= motor_in;
      level_ff       <= level_in;
      dur_ff         <= dur_in;
      digit_ff       <= digit_in;
      nib_ff         <= nib_in;
      csum_ff        <= csum_in;
      bad_ff         <= bad_in;
      res_status_ff  <= res_status_in;
      res_rpm_ff     <= res_rpm_in;
      res_written_ff <= res_written_in;
      res_cond_ff    <= res_cond_in;
      rsp_motor_ff   <= rsp_motor_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_rpm_ff     <= rsp_rpm_in;
      rsp_written_ff <= rsp_written_in;
      rsp_cond_ff    <= rsp_cond_in;
      rsp_fail_ff    <= rsp_fail_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.motor_id        = rsp_motor_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.rpm             = rsp_rpm_ff;
   assign rsp_bus.rpm_written     = rsp_written_ff;
   assign rsp_bus.condensed_value = rsp_cond_ff;
   assign rsp_bus.fail_mask       = rsp_fail_ff;

   // gcr digits only run on a frame padded to full length
   `ERPM_ASSERT(a_gcr_frame_full, clock, reset, state_ff == ST_GCR, bit_count_ff == BC_FULL)
   // the divides only run for frames that had a capture
   `ERPM_ASSERT(a_div_capture, clock, reset, state_ff == ST_DIV1 || state_ff == ST_DIV2,
                capture_ff)
   // divider finishes only while the sequencer waits for it
   `ERPM_ASSERT(a_done_in_div, clock, reset, div_rsp.done, state_ff == ST_DIV1 || state_ff == ST_DIV2)
   // a nonzero rpm only comes with a good, written result
   `ERPM_ASSERT(a_rpm_only_ok, clock, reset, rsp_valid_ff && rsp_rpm_ff != '0,
                rsp_status_ff == STATUS_OK && rsp_written_ff)
   // loading the output register ends the frame
   `ERPM_ASSERT_NEXT(a_out_to_idle, clock, reset, out_load, state_ff == ST_IDLE && rsp_valid_ff)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import erpm_td_pkg::*;

   // dut parameter, kept equal to the rtl default
   localparam int FRAME_WORDS  = 32;
   // quiet cycles after the last result: one long word plus the full decode
   localparam int DRAIN_CYCLES = 150;
   // long receiver hold-off so that the output register and the input back up
   localparam int HOLD_CYCLES  = 600;
   localparam int CYCLE_LIMIT  = 600000;

   // one captured edge word as offered on the request channel
   typedef struct {
      logic [MOTOR_W-1:0] motor;
      logic [WORD_W-1:0]  word;
      logic               first;
      logic               last;
   } edge_word_type;

   // one decoded telemetry frame as seen on the response channel
   typedef struct {
      logic [MOTOR_W-1:0]  motor_id;
      logic [STATUS_W-1:0] status;
      logic [RPM_W-1:0]    rpm;
      logic                rpm_written;
      logic [COND_W-1:0]   cond;
      logic [MASK_W-1:0]   fail_mask;
   } frame_result_type;

   // ways a generated frame can be spoiled
   typedef enum int {FLAW_NONE, FLAW_CSUM, FLAW_CODE, FLAW_LONG} frame_flaw_type;

   // tracks the decoder state word by word and holds the frames it must emit
   class erpm_frame_tracker;
      bit                enabled;
      int unsigned       poles;
      logic [31:0]       accum;
      int unsigned       nbits;
      bit                ended;
      bit                captured;
      logic [MASK_W-1:0] fail_bits;
      int unsigned       word_idx;
      frame_result_type  decoded_frames[$];
      int                failures;
      int                frames_seen;
      int                status_seen[5];

      function new();
         enabled     = 1'b1;
         poles       = 14;
         fail_bits   = '0;
         failures    = 0;
         frames_seen = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         accum    = '0;
         nbits    = 0;
         ended    = 1'b0;
         captured = 1'b0;
         word_idx = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_DSHOT_ENABLE) enabled = data[0];
         else if (index == CSR_POLE_COUNT) poles = data[6:0];
      endfunction

      // bit 4 marks a legal code
      function logic [4:0] gcr_to_nibble(logic [4:0] code);
         logic [4:0] e;
         case (code)
            5'd25:   e = 5'h10;
            5'd27:   e = 5'h11;
            5'd18:   e = 5'h12;
            5'd19:   e = 5'h13;
            5'd29:   e = 5'h14;
            5'd21:   e = 5'h15;
            5'd22:   e = 5'h16;
            5'd23:   e = 5'h17;
            5'd26:   e = 5'h18;
            5'd9:    e = 5'h19;
            5'd10:   e = 5'h1A;
            5'd11:   e = 5'h1B;
            5'd30:   e = 5'h1C;
            5'd13:   e = 5'h1D;
            5'd14:   e = 5'h1E;
            5'd15:   e = 5'h1F;
            default: e = 5'h00;
         endcase
         return e;
      endfunction

      function void shift_edge(logic [31:0] w);
         logic [31:0] raw;
         logic [31:0] dur;
         logic        lvl;
         raw = ~w & 32'h7FFF_FFFF;
         dur = (raw + 32'd3) / 32'd4;
         lvl = ~w[31];
         if (dur > FRAME_BITS) begin
            ended = 1'b1;
         end else if (dur != 0) begin
            accum = (accum << dur) | (lvl ? ((32'd1 << dur) - 32'd1) : 32'd0);
            nbits += dur;
            if (nbits > FRAME_BITS + 1) nbits = FRAME_BITS + 1;
         end
      endfunction

      function void decode_frame(logic [MOTOR_W-1:0] motor);
         frame_result_type  r;
         logic [MASK_W-1:0] mbit;
         logic [31:0]       x;
         logic [15:0]       v;
         logic [4:0]        e;
         logic [3:0]        cs;
         bit                ok;
         int unsigned       p;
         int unsigned       half;
         r.motor_id    = motor;
         r.status      = STATUS_OK;
         r.rpm         = '0;
         r.rpm_written = 1'b0;
         r.cond        = '0;
         mbit = MASK_W'(1) << motor;
         if (!captured) begin
            r.status = STATUS_NO_CAPTURE;
            fail_bits |= mbit;
         end else begin
            ok = (nbits <= FRAME_BITS);
            v  = '0;
            if (ok) begin
               x = (accum << (FRAME_BITS - nbits)) | (32'h1F_FFFF >> nbits);
               x = x ^ (x >> 1);
               for (int k = 0; k < 4; k++) begin
                  e = gcr_to_nibble(x[5*k +: 5]);
                  if (!e[4]) ok = 1'b0;
                  v[4*k +: 4] = e[3:0];
               end
               cs = v[15:12] ^ v[11:8] ^ v[7:4] ^ v[3:0];
               if (cs != CSUM_GOOD) ok = 1'b0;
            end
            if (!ok) begin
               r.status = STATUS_BAD_FRAME;
               fail_bits |= mbit;
            end else begin
               r.cond = v[15:4];
               if (r.cond == COND_STOPPED) begin
                  r.status      = STATUS_STOPPED;
                  r.rpm_written = 1'b1;
               end else begin
                  p = r.cond[8:0];
                  p = p << r.cond[11:9];
                  if (p == 0) begin
                     r.status = STATUS_ZERO_PERIOD;
                     fail_bits |= mbit;
                  end else begin
                     half = poles / 2;
                     if (half == 0) half = 1;
                     r.rpm         = RPM_W'(((32'd60000000 + 32'd50 * p) / p) / half);
                     r.rpm_written = 1'b1;
                     fail_bits &= ~mbit;
                  end
               end
            end
         end
         r.fail_mask = fail_bits;
         decoded_frames.push_back(r);
         status_seen[r.status]++;
      endfunction

      function void take_word(edge_word_type w);
         if (!enabled || w.motor >= MOTOR_COUNT) return;
         if (w.first) begin
            clear_frame();
            captured = (w.word != 0);
         end else if (word_idx < FRAME_WORDS - 1) begin
            if (!ended) shift_edge(w.word);
            word_idx++;
         end
         if (!w.last) return;
         decode_frame(w.motor);
         clear_frame();
      endfunction

      function void match_frame(frame_result_type got);
         frame_result_type want;
         if (decoded_frames.size() == 0) begin
            $error("result for motor %0d with no frame pending", got.motor_id);
            failures++;
            return;
         end
         want = decoded_frames.pop_front();
         frames_seen++;
         if (got.motor_id !== want.motor_id) begin
            $error("motor_id expected %0d actual %0d", want.motor_id, got.motor_id);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            failures++;
         end
         if (got.rpm !== want.rpm) begin
            $error("rpm expected %0d actual %0d", want.rpm, got.rpm);
            failures++;
         end
         if (got.rpm_written !== want.rpm_written) begin
            $error("rpm_written expected %0d actual %0d", want.rpm_written, got.rpm_written);
            failures++;
         end
         if (got.cond !== want.cond) begin
            $error("condensed_value expected %0h actual %0h", want.cond, got.cond);
            failures++;
         end
         if (got.fail_mask !== want.fail_mask) begin
            $error("fail_mask expected %0h actual %0h", want.fail_mask, got.fail_mask);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   erpm_td_req_if req_if ();
   erpm_td_rsp_if rsp_if ();
   erpm_td_csr_if csr_if ();

   erpm_telemetry_decoder #(.WORDS_PER_FRAME(FRAME_WORDS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   erpm_frame_tracker tracker = new();

   edge_word_type word_queue[$];   // words waiting to be offered
   int            words_sent;      // accepted request transactions
   bit            no_idle;         // final stretch: no gaps on either side
   bit            hold_request;    // asks the receiver for one long hold-off
   int unsigned   cycle_count = 0;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: a hung handshake or a missing result ends up here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // nibble to 5-bit gcr code, used to build well-formed frames
   function automatic logic [4:0] nibble_to_gcr(logic [3:0] n);
      logic [4:0] code;
      case (n)
         4'h0:    code = 5'd25;
         4'h1:    code = 5'd27;
         4'h2:    code = 5'd18;
         4'h3:    code = 5'd19;
         4'h4:    code = 5'd29;
         4'h5:    code = 5'd21;
         4'h6:    code = 5'd22;
         4'h7:    code = 5'd23;
         4'h8:    code = 5'd26;
         4'h9:    code = 5'd9;
         4'hA:    code = 5'd10;
         4'hB:    code = 5'd11;
         4'hC:    code = 5'd30;
         4'hD:    code = 5'd13;
         4'hE:    code = 5'd14;
         default: code = 5'd15;
      endcase
      return code;
   endfunction

   // now and then a word of a frame carries another motor's index
   function automatic logic [MOTOR_W-1:0] word_motor(logic [MOTOR_W-1:0] motor);
      if ($urandom_range(0, 19) == 0) return MOTOR_W'($urandom);
      return motor;
   endfunction

   task automatic add_word(input logic [MOTOR_W-1:0] motor, input logic [WORD_W-1:0] word,
                           input logic first, input logic last);
      edge_word_type w;
      w.motor = motor;
      w.word  = word;
      w.first = first;
      w.last  = last;
      word_queue.push_back(w);
   endtask

   // builds the edge words of one telemetry frame carrying cond, optionally spoiled
   task automatic queue_frame(input logic [MOTOR_W-1:0] motor, input logic [COND_W-1:0] cond,
                              input bit with_first, input frame_flaw_type flaw);
      logic [15:0] v;
      logic [19:0] d;
      logic [20:0] r;
      logic [31:0] c;
      logic        lvl;
      int          pos;
      int          len;
      int          ending;
      int          start_size;
      int          k;
      bit          drop_tail;
      bit          first_run;
      start_size = word_queue.size();
      // low nibble is the checksum that makes the four nibbles xor to all ones
      v = {cond, ~(cond[11:8] ^ cond[7:4] ^ cond[3:0])};
      if (flaw == FLAW_CSUM) v[3:0] ^= 4'($urandom_range(1, 15));
      for (k = 0; k < 4; k++) d[5*k +: 5] = nibble_to_gcr(v[4*k +: 4]);
      if (flaw == FLAW_CODE) begin
         k = $urandom_range(0, 3);
         d[5*k +: 5] = 5'($urandom);
      end
      // undo the transition coding: line bits whose x ^ x>>1 gives the codes
      r[20] = 1'($urandom);
      for (pos = 19; pos >= 0; pos--) r[pos] = d[pos] ^ r[pos+1];
      if (with_first) begin
         c = $urandom;
         if (c == 0) c = 32'd1;
         add_word(motor, c, 1'b1, 1'b0);
      end
      // one word per run of equal line bits, msb first, now and then followed by a
      // zero-duration word; a trailing run of ones may be left to the padding
      drop_tail = 1'($urandom);
      first_run = 1'b1;
      pos = 20;
      while (pos >= 0) begin
         lvl = r[pos];
         len = 0;
         while (pos >= 0 && r[pos] == lvl) begin
            len++;
            pos--;
         end
         if (first_run && flaw == FLAW_LONG) len++;
         first_run = 1'b0;
         if (!(pos < 0 && lvl && drop_tail)) begin
            // any countdown in 4*len-3 .. 4*len rounds to len bits
            c = 32'(4 * len - $urandom_range(0, 3));
            add_word(word_motor(motor), {~lvl, ~c[30:0]}, 1'b0, 1'b0);
            if ($urandom_range(0, 9) == 0)
               add_word(word_motor(motor), {1'($urandom), 31'h7FFF_FFFF}, 1'b0, 1'b0);
         end
      end
      ending = $urandom_range(0, 2);
      if (word_queue.size() == start_size) ending = 1;
      if (ending == 1) begin
         // zero-duration word closes the frame
         add_word(word_motor(motor), {1'($urandom), 31'h7FFF_FFFF}, 1'b0, 1'b0);
      end else if (ending == 2) begin
         // overlong edge ends the frame, later words are dropped by the block
         if ($urandom_range(0, 1)) c = $urandom_range(85, 400);
         else c = ($urandom & 32'h7FFF_FFFF) | 32'h100;
         add_word(word_motor(motor), {1'($urandom), ~c[30:0]}, 1'b0, 1'b0);
         repeat ($urandom_range(0, 2)) add_word(word_motor(motor), $urandom, 1'b0, 1'b0);
      end
      word_queue[word_queue.size()-1].last = 1'b1;
   endtask

   // loose words with random flags
   task automatic queue_noise();
      logic first;
      logic last;
      logic [31:0] w;
      repeat ($urandom_range(1, 8)) begin
         first = ($urandom_range(0, 4) == 0);
         last  = ($urandom_range(0, 4) == 0);
         w = (first && $urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
         add_word(MOTOR_W'($urandom), w, first, last);
      end
   endtask

   // more data words than a frame holds, short edges only
   task automatic queue_long_frame(input logic [MOTOR_W-1:0] motor);
      logic [31:0] c;
      add_word(motor, $urandom | 32'd1, 1'b1, 1'b0);
      repeat ($urandom_range(33, 36)) begin
         c = $urandom_range(0, 8);
         add_word(motor, {1'($urandom), ~c[30:0]}, 1'b0, 1'b0);
      end
      word_queue[word_queue.size()-1].last = 1'b1;
   endtask

   task automatic queue_random_frame();
      int                 kind;
      int                 pick;
      logic [MOTOR_W-1:0] m;
      logic [COND_W-1:0]  cond;
      frame_flaw_type     flaw;
      kind = $urandom_range(0, 99);
      m    = MOTOR_W'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
         0:       cond = COND_STOPPED;
         1:       cond = {3'($urandom), 9'h000};
         2:       cond = {3'($urandom), 9'h001};
         3:       cond = 12'hFFE;
         default: cond = COND_W'($urandom);
      endcase
      pick = $urandom_range(0, 19);
      case (pick)
         0:       flaw = FLAW_CSUM;
         1:       flaw = FLAW_CODE;
         2:       flaw = FLAW_LONG;
         default: flaw = FLAW_NONE;
      endcase
      if (kind < 75) queue_frame(m, cond, 1'b1, flaw);
      else if (kind < 85) queue_frame(m, cond, 1'b0, flaw);   // word 0 missing
      else if (kind < 93) queue_noise();
      else if (kind < 97) queue_long_frame(m);
      else add_word(m, $urandom_range(0, 1) ? 32'd0 : $urandom, 1'b1, 1'b1);
   endtask

   // offers every queued word; valid stays high across back-to-back transactions
   task automatic send_words();
      edge_word_type w;
      while (word_queue.size() > 0) begin
         w = word_queue.pop_front();
         req_if.valid        <= 1'b1;
         req_if.motor        <= w.motor;
         req_if.capture_word <= w.word;
         req_if.first_word   <= w.first;
         req_if.last_word    <= w.last;
         do @(posedge clock); while (!req_if.ready);
         tracker.take_word(w);
         words_sent++;
         if (!no_idle && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   endtask

   task automatic run_frames(input int n_words);
      int start;
      start = words_sent;
      while (words_sent - start < n_words) begin
         queue_random_frame();
         send_words();
      end
      req_if.valid <= 1'b0;
   endtask

   // wait for every pending frame, then let a possible last decode finish
   task automatic settle();
      while (tracker.decoded_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // writes both registers in back-to-back csr transactions
   task automatic program_regs(input bit enable, input int unsigned poles);
      csr_if.valid <= 1'b1;
      csr_if.index <= CSR_DSHOT_ENABLE;
      csr_if.data  <= CSR_DATA_W'(enable);
      do @(posedge clock); while (!csr_if.ready);
      tracker.set_reg(CSR_DSHOT_ENABLE, CSR_DATA_W'(enable));
      csr_if.index <= CSR_POLE_COUNT;
      csr_if.data  <= CSR_DATA_W'(poles);
      do @(posedge clock); while (!csr_if.ready);
      tracker.set_reg(CSR_POLE_COUNT, CSR_DATA_W'(poles));
      csr_if.valid <= 1'b0;
   endtask

   // response side: checks each transaction, stalls in short random bursts and
   // once for a long stretch while the sender keeps going
   initial begin
      int               stall_left;
      int               hold_left;
      frame_result_type got;
      stall_left   = 0;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.motor_id    = rsp_if.motor_id;
            got.status      = rsp_if.status;
            got.rpm         = rsp_if.rpm;
            got.rpm_written = rsp_if.rpm_written;
            got.cond        = rsp_if.condensed_value;
            got.fail_mask   = rsp_if.fail_mask;
            tracker.match_frame(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (no_idle) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // stimulus: directed frames at reset settings, then random phases with
   // different register settings, each started from an idle block
   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.motor        = '0;
      req_if.capture_word = '0;
      req_if.first_word   = 1'b0;
      req_if.last_word    = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.index        = '0;
      csr_if.data         = '0;
      no_idle             = 1'b0;
      hold_request        = 1'b0;
      words_sent          = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part, registers still at their reset values
      add_word(2'd1, $urandom, 1'b0, 1'b1);        // last word with no word 0 since reset
      add_word(2'd2, 32'd0, 1'b1, 1'b1);           // word 0 and last at once, no capture
      queue_frame(2'd2, 12'h001, 1'b1, FLAW_NONE); // shortest period, highest rpm
      queue_frame(2'd3, COND_STOPPED, 1'b1, FLAW_NONE);
      queue_frame(2'd0, 12'hE00, 1'b1, FLAW_NONE); // mantissa zero, zero period
      send_words();
      req_if.valid <= 1'b0;
      settle();

      // smallest legal pole count
      program_regs(1'b1, 2);
      run_frames(300);
      settle();

      // pole count of 64, the largest this bench uses
      program_regs(1'b1, 64);
      run_frames(300);
      settle();

      // half pole count of zero
      program_regs(1'b1, 1);
      run_frames(120);
      settle();

      // decoder disabled, everything offered is dropped
      program_regs(1'b0, 14);
      run_frames(60);
      settle();

      // back on, with a long receiver hold-off in the middle
      program_regs(1'b1, $urandom_range(2, 64));
      run_frames(100);
      hold_request = 1'b1;
      run_frames(250);
      settle();

      // final stretch without gaps
      program_regs(1'b1, 3);
      no_idle = 1'b1;
      run_frames(300);
      settle();

      $display("%0d edge words offered, %0d frames decoded, pole counts 14/2/64/1/3/random",
               words_sent, tracker.frames_seen);
      $display("frame outcomes: ok %0d, stopped %0d, no capture %0d, bad %0d, zero period %0d",
               tracker.status_seen[0], tracker.status_seen[1], tracker.status_seen[2],
               tracker.status_seen[3], tracker.status_seen[4]);
      if (tracker.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
